// File: rtl/fixed_priority_task_selector_defines.svh
// ----------------------------------------------------------------------------
// Fixed-priority task selector: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef FIXED_PRIORITY_TASK_SELECTOR_DEFINES_SVH
`define FIXED_PRIORITY_TASK_SELECTOR_DEFINES_SVH

// Same-cycle implication.
`define FPTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FPTS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/fpts_pkg.sv
// ----------------------------------------------------------------------------
// fpts_pkg
// Operation codes, field widths and shared types of the task selector.
// ----------------------------------------------------------------------------
`default_nettype none

package fpts_pkg;

  localparam int OPC_W         = 3;
  localparam int PRIO_W        = 8;
  localparam int TIME_W        = 32;
  localparam int ID_W          = 4;
  localparam int MAX_TASKS_DEF = 16;

  localparam logic [OPC_W-1:0] OP_ADD   = 3'd0;
  localparam logic [OPC_W-1:0] OP_TICK  = 3'd1;
  localparam logic [OPC_W-1:0] OP_DELAY = 3'd2;
  localparam logic [OPC_W-1:0] OP_BLOCK = 3'd3;
  localparam logic [OPC_W-1:0] OP_SCHED = 3'd4;

  // One task entry as read back from the tables during a scan.
  typedef struct packed {
    logic              blocked;
    logic [TIME_W-1:0] wake;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Best candidate found so far in a scan.
  typedef struct packed {
    logic              have;
    logic [PRIO_W-1:0] prio;
  } best_t;

endpackage

`default_nettype wire

// File: rtl/fpts_ram.sv
// ----------------------------------------------------------------------------
// fpts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fpts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/fpts_cmp.sv
// ----------------------------------------------------------------------------
// fpts_cmp
// Shared scan compare unit: decides whether one entry replaces the best so far.
// ----------------------------------------------------------------------------
`default_nettype none

module fpts_cmp import fpts_pkg::*; (
  input  wire entry_t            cand,
  input  wire best_t             best,
  input  wire logic [TIME_W-1:0] tick_count,
  output logic                   take
);

  logic ready;

  // A task is eligible when it is not blocked and its wake time has passed.
  // A strict less-than keeps the lower slot on a tie.
  always_comb begin
    ready = !cand.blocked && (cand.wake <= tick_count);
    take  = ready && (!best.have || (cand.prio < best.prio));
  end

endmodule

`default_nettype wire

// File: rtl/fixed_priority_task_selector.sv
// ----------------------------------------------------------------------------
// fixed_priority_task_selector
// Fixed-priority task selector with tick-based delays for a small kernel.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Payload
//   input    in_valid, in_stall    opcode, priority_req, timeout, task_index, blocked_value
//   output   out_valid, out_stall  task_id, found
//
// Add, tick, delay, set-blocked and unused opcodes take effect at the accepting edge,
// and their result beat is offered in the next cycle.
// Schedule reads one counted slot per cycle through a single compare unit and loads
// its result in ST_LAST after the last slot is judged (at once with no task added).
// Reset clears the tick counter, task count, running task, sequencer, scan and handshake state only.
// The input stalls during a scan and while a stalled output holds a result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_priority_task_selector import fpts_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OPC_W-1:0]  opcode,
  input  wire logic [PRIO_W-1:0] priority_req,
  input  wire logic [TIME_W-1:0] timeout,
  input  wire logic [3:0]        task_index,
  input  wire logic              blocked_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [ID_W-1:0]        task_id,
  output logic                   found
);

`include "fixed_priority_task_selector_defines.svh"

  // Slot addresses cover the table depth.
  localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(MAX_TASKS - 1);
  localparam logic [SLOT_W-1:0] SLOT_ONE  = SLOT_W'(1);

  // Sequencer states.
  localparam int STATE_W = 2;
  localparam logic [STATE_W-1:0] ST_IDLE = 2'd0;
  localparam logic [STATE_W-1:0] ST_SCAN = 2'd1;
  localparam logic [STATE_W-1:0] ST_LAST = 2'd2;

  logic [STATE_W-1:0] state;
  logic [TIME_W-1:0]  tick_count;
  logic [SLOT_W-1:0]  task_total;
  logic [SLOT_W-1:0]  task_total_next;
  logic [SLOT_W-1:0]  running_task;
  logic [SLOT_W-1:0]  scan_idx;
  logic               rd_vld;
  logic [SLOT_W-1:0]  rd_idx;
  logic               best_have;
  logic [PRIO_W-1:0]  best_prio;
  logic [SLOT_W-1:0]  best_idx;

  logic in_accept;
  logic out_take;
  logic idx_ok;
  logic take;
  logic take_vld;
  logic fin_have;
  logic [SLOT_W-1:0] fin_idx;

  // Table write and read ports.
  logic               prio_we;
  logic               wake_we;
  logic [SLOT_W-1:0]  wake_waddr;
  logic [TIME_W-1:0]  wake_wdata;
  logic               blk_we;
  logic [SLOT_W-1:0]  blk_waddr;
  logic               blk_wdata;
  logic [PRIO_W-1:0]  prio_rd;
  logic [TIME_W-1:0]  wake_rd;
  logic               blk_rd;

  entry_t cand;
  best_t  best;

  // The input side waits during a scan, and while a result beat is held back.
  assign in_stall  = (state != ST_IDLE) || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  // Set-blocked on a slot beyond the table is dropped.
  assign idx_ok = (32'(task_index) < MAX_TASKS);

  // The count saturates at the last slot, so repeated adds keep rewriting it.
  assign task_total_next = (task_total == SLOT_LAST) ? SLOT_LAST : task_total + SLOT_ONE;

  // All table writes happen in the accept cycle. Add initializes a whole
  // entry; delay and set-blocked each touch one table.
  always_comb begin
    prio_we    = in_accept && (opcode == OP_ADD);
    wake_we    = in_accept && (opcode inside {OP_ADD, OP_DELAY});
    wake_waddr = (opcode == OP_ADD) ? task_total : running_task;
    wake_wdata = (opcode == OP_ADD) ? '0 : timeout + tick_count;
    blk_we     = in_accept && ((opcode == OP_ADD) || ((opcode == OP_BLOCK) && idx_ok));
    blk_waddr  = (opcode == OP_ADD) ? task_total : SLOT_W'(task_index);
    blk_wdata  = (opcode == OP_ADD) ? 1'b0 : blocked_value;
  end

  fpts_ram #(.WIDTH(PRIO_W), .DEPTH(MAX_TASKS)) u_prio_ram (
    .clk   (clk),
    .we    (prio_we),
    .waddr (task_total),
    .wdata (priority_req),
    .raddr (scan_idx),
    .rdata (prio_rd)
  );

  fpts_ram #(.WIDTH(TIME_W), .DEPTH(MAX_TASKS)) u_wake_ram (
    .clk   (clk),
    .we    (wake_we),
    .waddr (wake_waddr),
    .wdata (wake_wdata),
    .raddr (scan_idx),
    .rdata (wake_rd)
  );

  fpts_ram #(.WIDTH(1), .DEPTH(MAX_TASKS)) u_blk_ram (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .raddr (scan_idx),
    .rdata (blk_rd)
  );

  // The read data of slot rd_idx arrives in the cycle after its address was
  // issued and is judged against the best candidate by the compare unit.
  always_comb begin
    cand.blocked = blk_rd;
    cand.wake    = wake_rd;
    cand.prio    = prio_rd;
    best.have    = best_have;
    best.prio    = best_prio;
  end

  fpts_cmp u_cmp (
    .cand       (cand),
    .best       (best),
    .tick_count (tick_count),
    .take       (take)
  );

  assign take_vld = rd_vld && take;
  assign fin_have = best_have || take_vld;
  assign fin_idx  = take_vld ? rd_idx : best_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      tick_count   <= '0;
      task_total   <= '0;
      running_task <= '0;
      rd_vld       <= 1'b0;
      best_have    <= 1'b0;
    end else begin
      rd_vld <= (state == ST_SCAN);
      rd_idx <= scan_idx;

      if (out_take) begin
        out_valid <= 1'b0;
      end

      // Fold the slot that just came back from the tables into the best.
      if (take_vld) begin
        best_have <= 1'b1;
        best_prio <= prio_rd;
        best_idx  <= rd_idx;
      end

      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            // Most operations answer at once with a zero slot and no find.
            out_valid <= 1'b1;
            task_id   <= '0;
            found     <= 1'b0;
            case (opcode)
              OP_ADD: begin
                task_id    <= ID_W'(task_total);
                task_total <= task_total_next;
              end
              OP_TICK: begin
                tick_count <= tick_count + 32'd1;
              end
              OP_SCHED: begin
                // With no task counted there is nothing to scan.
                if (task_total != '0) begin
                  out_valid <= 1'b0;
                  scan_idx  <= '0;
                  best_have <= 1'b0;
                  state     <= ST_SCAN;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_idx == task_total - SLOT_ONE) begin
            state <= ST_LAST;
          end else begin
            scan_idx <= scan_idx + SLOT_ONE;
          end
        end
        ST_LAST: begin
          // The last slot's data is judged here and the result is loaded.
          out_valid <= 1'b1;
          found     <= fin_have;
          task_id   <= fin_have ? ID_W'(fin_idx) : '0;
          if (fin_have) begin
            running_task <= fin_idx;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The task count never reaches the table depth.
  `FPTS_ASSERT_IMP(a_total_range, 1'b1, 32'(task_total) < MAX_TASKS, "task count out of range")

  // A scan only starts with an empty result slot and never fills it early.
  `FPTS_ASSERT_IMP(a_scan_no_out, state != ST_IDLE, !out_valid, "result shown during scan")

  // A found task is always one of the counted slots.
  `FPTS_ASSERT_IMP(a_found_counted, out_valid && found, 32'(task_id) < 32'(task_total),
                   "found task beyond task count")

  // Every operation other than schedule answers on the next cycle.
  `FPTS_ASSERT_NXT(a_quick_op, in_accept && (opcode != OP_SCHED), out_valid,
                   "single-cycle operation gave no result")

endmodule

`default_nettype wire

// File: verif/task_selector_checker.sv
// ----------------------------------------------------------------------------
// Task selector checker
// Watches both channels of the task selector. It keeps its own copy of the
// task tables, predicts the result of every accepted input beat and compares
// each result beat with the oldest prediction.
// ----------------------------------------------------------------------------
module task_selector_checker import fpts_pkg::*; #(
  parameter int SLOTS = MAX_TASKS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [OPC_W-1:0]  opcode,
  input  logic [PRIO_W-1:0] priority_req,
  input  logic [TIME_W-1:0] timeout,
  input  logic [3:0]        task_index,
  input  logic              blocked_value,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [ID_W-1:0]   task_id,
  input  logic              found,
  output int                outstanding,
  output int                mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ID_W-1:0] slot;
    logic            found;
  } outcome_t;

  logic [TIME_W-1:0] ticks;
  int                task_count;
  int                running;
  logic [PRIO_W-1:0] prio_tab[SLOTS];
  logic [TIME_W-1:0] wake_tab[SLOTS];
  logic              blocked_tab[SLOTS];
  outcome_t          outcome_q[$];

  // Applies one operation to the shadow kernel state and returns its result.
  function automatic outcome_t apply_kernel_op(input logic [OPC_W-1:0]  op,
                                               input logic [PRIO_W-1:0] prio,
                                               input logic [TIME_W-1:0] tmo,
                                               input logic [3:0]        idx,
                                               input logic              bval);
    outcome_t res;
    int       slot;
    int       best;
    bit       have;
    res  = '0;
    best = 0;
    have = 1'b0;
    case (op)
      OP_ADD: begin
        slot = (task_count >= SLOTS) ? SLOTS - 1 : task_count;
        prio_tab[slot]    = prio;
        wake_tab[slot]    = '0;
        blocked_tab[slot] = 1'b0;
        res.slot          = ID_W'(slot);
        task_count        = (slot + 1 >= SLOTS) ? SLOTS - 1 : slot + 1;
      end
      OP_TICK:  ticks = ticks + 1'b1;
      OP_DELAY: if (running < SLOTS) wake_tab[running] = tmo + ticks;
      OP_BLOCK: if (idx < SLOTS) blocked_tab[idx] = bval;
      OP_SCHED: begin
        // Strict less-than keeps the lower slot on a priority tie.
        for (int i = 0; i < task_count; i++) begin
          if (!blocked_tab[i] && wake_tab[i] <= ticks &&
              (!have || prio_tab[i] < prio_tab[best])) begin
            best = i;
            have = 1'b1;
          end
        end
        if (have) begin
          running   = best;
          res.slot  = ID_W'(best);
          res.found = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    outcome_t want;
    if (rst) begin
      ticks      = '0;
      task_count = 0;
      running    = 0;
      outcome_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: task_id=%0d found=%0b",
                   $time, task_id, found);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          if (task_id !== want.slot) begin
            $display("%0t: task_id mismatch: expected %0d, actual %0d",
                     $time, want.slot, task_id);
            mismatches++;
          end
          if (found !== want.found) begin
            $display("%0t: found mismatch: expected %0b, actual %0b",
                     $time, want.found, found);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        outcome_q.push_back(apply_kernel_op(opcode, priority_req, timeout,
                                            task_index, blocked_value));
      end
    end
    outstanding <= outcome_q.size();
  end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Task selector testbench
// Drives directed and then random kernel operations into the task selector,
// with bursty input traffic and a stalling receiver, and reports the verdict
// of the checker that runs beside the block.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fpts_pkg::*;

  localparam int SLOTS         = MAX_TASKS_DEF;
  localparam int CLK_PERIOD    = 4;
  localparam int RESET_CYCLES  = 10;
  localparam int RANDOM_ITEMS  = 650;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 120;
  // A slow but correct run is roughly 700 beats, each with a full scan, a
  // sender gap and a receiver stall, plus two long holds. The limit gives
  // ample margin.
  localparam int CYCLE_LIMIT   = 400000;

  // Opcodes the block does not define; they must answer with an empty result.
  localparam logic [OPC_W-1:0] OP_SPARE5 = 3'd5;
  localparam logic [OPC_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OPC_W-1:0] OP_SPARE7 = 3'd7;

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              in_valid      = 1'b0;
  logic [OPC_W-1:0]  opcode        = OP_TICK;
  logic [PRIO_W-1:0] priority_req  = '0;
  logic [TIME_W-1:0] timeout       = '0;
  logic [3:0]        task_index    = '0;
  logic              blocked_value = 1'b0;
  logic              out_stall     = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [ID_W-1:0]   task_id;
  logic              found;

  int outstanding;
  int mismatches;
  int cycle_count = 0;
  int burst_left  = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  fixed_priority_task_selector #(
    .MAX_TASKS(SLOTS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .priority_req (priority_req),
    .timeout      (timeout),
    .task_index   (task_index),
    .blocked_value(blocked_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .task_id      (task_id),
    .found        (found)
  );

  task_selector_checker #(
    .SLOTS(SLOTS)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .priority_req (priority_req),
    .timeout      (timeout),
    .task_index   (task_index),
    .blocked_value(blocked_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .task_id      (task_id),
    .found        (found),
    .outstanding  (outstanding),
    .mismatches   (mismatches)
  );

  // Offers one input beat and holds it until the block takes it. All signals
  // are driven at the rising edge and in_stall is sampled at the edge, so the
  // beat is accepted at the first edge that sees in_stall low. Afterwards the
  // sender either keeps going in its current burst or drops valid for a gap.
  // When there is no gap, valid simply stays high into the next beat; it is
  // only assigned once per time step.
  task automatic push_op(input logic [OPC_W-1:0]  op,
                         input logic [PRIO_W-1:0] prio,
                         input logic [TIME_W-1:0] tmo,
                         input logic [3:0]        idx,
                         input logic              bval);
    int gap;
    in_valid      <= 1'b1;
    opcode        <= op;
    priority_req  <= prio;
    timeout       <= tmo;
    task_index    <= idx;
    blocked_value <= bval;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // A new burst starts. One burst in five runs back to back with the last.
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Stops offering beats until the checker has seen every expected result.
  // The checker publishes its count as a registered value, so the task drops
  // valid and lets the clock advance before its first look.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    logic [OPC_W-1:0]  op;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] tmo;
    logic [3:0]        idx;
    logic              bval;
    int                roll;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The empty table, operations before any task exists,
    // the spare opcodes, extreme priorities and a priority tie come first.
    push_op(OP_SCHED, 8'd0,   32'd0,        4'd0,  1'b0);
    push_op(OP_DELAY, 8'd0,   32'd5,        4'd0,  1'b0);
    push_op(OP_BLOCK, 8'd0,   32'd0,        4'd3,  1'b1);
    push_op(OP_SPARE5, 8'hFF, 32'hFFFFFFFF, 4'hF,  1'b1);
    push_op(OP_SPARE6, 8'h00, 32'h00000000, 4'h0,  1'b0);
    push_op(OP_SPARE7, 8'hA5, 32'h5A5A5A5A, 4'hA,  1'b1);
    push_op(OP_TICK,  8'd0,   32'd0,        4'd0,  1'b0);
    push_op(OP_ADD,   8'd255, 32'd0,        4'd0,  1'b0);
    push_op(OP_ADD,   8'd0,   32'd0,        4'd0,  1'b0);
    push_op(OP_ADD,   8'd0,   32'd0,        4'd0,  1'b0);
    push_op(OP_SCHED, 8'd0,   32'd0,        4'd0,  1'b0);
    push_op(OP_BLOCK, 8'd0,   32'd0,        4'd1,  1'b1);
    push_op(OP_SCHED, 8'd0,   32'd0,        4'd0,  1'b0);
    // Delay the running task so that it is not ready, then block the rest
    // so that a scan finds nothing and the running task stays as it was.
    push_op(OP_DELAY, 8'd0,   32'd3,        4'd0,  1'b0);
    push_op(OP_SCHED, 8'd0,   32'd0,        4'd0,  1'b0);
    push_op(OP_BLOCK, 8'd0,   32'd0,        4'd0,  1'b1);
    push_op(OP_SCHED, 8'd0,   32'd0,        4'd0,  1'b0);
    push_op(OP_TICK,  8'd0,   32'd0,        4'd0,  1'b0);
    push_op(OP_TICK,  8'd0,   32'd0,        4'd0,  1'b0);
    push_op(OP_TICK,  8'd0,   32'd0,        4'd0,  1'b0);
    push_op(OP_SCHED, 8'd0,   32'd0,        4'd0,  1'b0);
    // The largest timeout wraps the wake time below the tick counter.
    push_op(OP_DELAY, 8'd0,   32'hFFFFFFFF, 4'd0,  1'b0);
    push_op(OP_SCHED, 8'd0,   32'd0,        4'd0,  1'b0);
    // A slot that was never added, then unblocking a waiting task.
    push_op(OP_BLOCK, 8'd0,   32'd0,        4'd15, 1'b1);
    push_op(OP_BLOCK, 8'd0,   32'd0,        4'd1,  1'b0);
    push_op(OP_SCHED, 8'd0,   32'd0,        4'd0,  1'b0);
    wait_drained();

    // Random part. Adds are sparse enough that the scan length grows over
    // time and the table fills up about a fifth of the way through, after
    // which adds keep overwriting the top slot.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10)      op = OP_ADD;
      else if (roll < 30) op = OP_TICK;
      else if (roll < 45) op = OP_DELAY;
      else if (roll < 65) op = OP_BLOCK;
      else if (roll < 95) op = OP_SCHED;
      else begin
        case ($urandom_range(0, 2))
          0:       op = OP_SPARE5;
          1:       op = OP_SPARE6;
          default: op = OP_SPARE7;
        endcase
      end

      // Half the priorities come from a tiny range so that ties are common.
      if ($urandom_range(0, 1) == 0) prio = PRIO_W'($urandom_range(0, 3));
      else                           prio = PRIO_W'($urandom_range(0, 255));

      // Short timeouts make tasks wake up within a few ticks; the long and
      // near-maximum ones exercise both far-away and wrapped wake times.
      roll = $urandom_range(0, 9);
      if (roll < 4)       tmo = TIME_W'($urandom_range(0, 4));
      else if (roll < 6)  tmo = TIME_W'($urandom_range(0, 20));
      else if (roll < 8)  tmo = $urandom();
      else if (roll < 9)  tmo = 32'hFFFFFFFF - TIME_W'($urandom_range(0, 8));
      else                tmo = '0;

      idx  = 4'($urandom_range(0, 15));
      // Unblocking is favored so that scans keep finding tasks.
      bval = ($urandom_range(0, 9) < 4);

      if (n == RANDOM_ITEMS / 2) wait_drained();
      push_op(op, prio, tmo, idx, bval);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Receiver. It changes its stall behavior at random intervals: no stall,
  // light or heavy random stall, or a square wave. Twice in the run it holds
  // off for a long stretch, so that one result beat sits in the block and the
  // input side backs up while the sender keeps offering.
  initial begin : receiver
    int mode;
    int span;
    int rx_cycles;
    int holds;
    int next_hold;
    rx_cycles = 0;
    holds     = 0;
    next_hold = 300;
    while (rst) @(posedge clk);
    forever begin
      if (holds < 2 && rx_cycles >= next_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        rx_cycles += LONG_HOLD;
        holds++;
        next_hold = rx_cycles + 4000;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(4, 48);
        repeat (span) begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ((rx_cycles % 6) < 3);
          endcase
          @(posedge clk);
          rx_cycles++;
        end
      end
    end
  end

  // Watchdog. A run that does not finish within the limit is a failure.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
